// ----- rtl/complex_arithmetic_unit_assert.svh -----
// Assertion macros for the complex arithmetic unit.
// Needs a clk_i and an active-low rst_ni in the module that uses them.
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define CAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define CAU_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define CAU_ASSERT(lbl, prop, msg)
`define CAU_NEVER(lbl, cond, msg)
`endif
`endif

// ----- rtl/cau_pkg.sv -----
// Shared types and constants of the complex arithmetic unit.
// No dependencies.
package cau_pkg;

  localparam int unsigned CMD_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_EQ  = 3'd4
  } cmd_e;

  // Flags that travel with an item through the divider stages.
  typedef struct packed {
    logic       is_div;
    logic       zdiv;
    logic       eq;
    logic       ovf;
    logic [1:0] neg;   // quotient sign, [0] real, [1] imaginary
    logic [1:0] big;   // quotient magnitude out of range
  } div_ctl_t;

endpackage

// ----- rtl/cau_if.sv -----
// Valid/ready channel interfaces of the complex arithmetic unit.
// Depends on cau_pkg.
interface cau_in_if #(
  parameter int unsigned DATA_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic [cau_pkg::CMD_W-1:0]     cmd;
  logic signed [DATA_WIDTH-1:0]  a_re;
  logic signed [DATA_WIDTH-1:0]  a_im;
  logic signed [DATA_WIDTH-1:0]  b_re;
  logic signed [DATA_WIDTH-1:0]  b_im;

  modport source (output valid, cmd, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, cmd, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_out_if #(
  parameter int unsigned DATA_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [DATA_WIDTH-1:0]  res_re;
  logic signed [DATA_WIDTH-1:0]  res_im;
  logic                          equal_flag;
  logic                          zero_divisor;
  logic                          overflow;

  modport source (output valid, res_re, res_im, equal_flag, zero_divisor, overflow,
                  input ready);
  modport sink   (input valid, res_re, res_im, equal_flag, zero_divisor, overflow,
                  output ready);
endinterface

// ----- rtl/cau_div.sv -----
// Pipelined restoring divider, two lanes sharing one divisor, one quotient bit per stage.
// Depends on cau_pkg.
module cau_div #(
  parameter int unsigned DW = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  cau_pkg::div_ctl_t      ctl_i,
  input  logic [2*DW-1:0]        den_i,
  input  logic [2*DW-1:0]        rem_i [2],
  input  logic [DW-1:0]          xlo_i [2],
  input  logic [DW-1:0]          res_i [2],
  output logic                   valid_o,
  output cau_pkg::div_ctl_t      ctl_o,
  output logic [DW-1:0]          q_o [2],
  output logic [DW-1:0]          res_o [2]
);
  import cau_pkg::*;

  localparam int unsigned PW = 2 * DW;

  logic [DW-1:0] v_q;
  logic [PW-1:0] rem_q [DW][2];
  logic [DW-1:0] x_q   [DW][2];
  logic [DW-1:0] quo_q [DW][2];
  logic [DW-1:0] res_q [DW][2];
  logic [PW-1:0] den_q [DW];
  div_ctl_t      ctl_q [DW];

  // {quotient bit, next remainder}
  function automatic logic [PW:0] div_step(logic [PW-1:0] rem, logic inb, logic [PW-1:0] den);
    logic [PW:0] r;
    logic [PW:0] d;
    r = {rem, inb};
    d = r - {1'b0, den};
    if (r >= {1'b0, den}) begin
      return {1'b1, d[PW-1:0]};
    end
    return {1'b0, r[PW-1:0]};
  endfunction

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic          v_s;
    div_ctl_t      ctl_s;
    logic [PW-1:0] den_s;
    logic [PW-1:0] rem_s [2];
    logic [DW-1:0] x_s   [2];
    logic [DW-1:0] quo_s [2];
    logic [DW-1:0] res_s [2];
    logic [PW:0]   st    [2];

    if (k == 0) begin : g_head
      always_comb begin
        v_s   = valid_i;
        ctl_s = ctl_i;
        den_s = den_i;
        for (int l = 0; l < 2; l++) begin
          rem_s[l] = rem_i[l];
          x_s[l]   = xlo_i[l];
          quo_s[l] = '0;
          res_s[l] = res_i[l];
        end
      end
    end else begin : g_body
      always_comb begin
        v_s   = v_q[k-1];
        ctl_s = ctl_q[k-1];
        den_s = den_q[k-1];
        for (int l = 0; l < 2; l++) begin
          rem_s[l] = rem_q[k-1][l];
          x_s[l]   = x_q[k-1][l];
          quo_s[l] = quo_q[k-1][l];
          res_s[l] = res_q[k-1][l];
        end
      end
    end

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        st[l] = div_step(rem_s[l], x_s[l][DW-1], den_s);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ctl_q[k] <= ctl_s;
        den_q[k] <= den_s;
        for (int l = 0; l < 2; l++) begin
          rem_q[k][l] <= st[l][PW-1:0];
          x_q[k][l]   <= x_s[l] << 1;
          quo_q[k][l] <= {quo_s[l][DW-2:0], st[l][PW]};
          res_q[k][l] <= res_s[l];
        end
      end
    end
  end

  assign valid_o = v_q[DW-1];
  assign ctl_o   = ctl_q[DW-1];
  assign q_o     = quo_q[DW-1];
  assign res_o   = res_q[DW-1];

endmodule

// ----- rtl/complex_arithmetic_unit.sv -----
// Complex arithmetic unit: add, subtract, multiply, divide, compare on signed fixed point.
// Depends on cau_pkg, cau_if (cau_in_if, cau_out_if), cau_div and the assertion header.
//
// Channels: in_i (sink) carries cmd and operands a, b; out_o (source) carries the
// saturated result, equal_flag, zero_divisor and overflow. A transfer happens on a
// clock edge with valid and ready both high. Every command yields exactly one result.
// Every command takes the same path: three stages of split multiply and sums,
// two stages of divide setup, one stage per quotient bit in cau_div, and the
// output register. One transfer is taken per cycle while no stall holds it.
// The whole pipeline advances on one enable: it moves when the output register is
// empty or is being drained; when the receiver holds ready low with a result waiting,
// every stage holds and in_i.ready drops, so nothing is lost or repeated.
// Reset (rst_ni, asynchronous, active low) clears all stage valid bits; data
// registers are not reset. Undefined cmd codes give an all-zero result.
module complex_arithmetic_unit #(
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cau_in_if.sink      in_i,
  cau_out_if.source   out_o
);
  import cau_pkg::*;

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned H  = (W + 1) / 2;          // low half, unsigned
  localparam int unsigned HW = W - H;                // high half, signed
  localparam int unsigned PW = 2 * W;                // full product
  localparam int unsigned NW = PW + 1;               // sum of two products
  localparam int unsigned SW = PW + 2;               // work width before saturation
  localparam int unsigned NX = PW + F;               // scaled dividend magnitude
  localparam int unsigned XH = W + F;                // dividend above quotient bits
  localparam int unsigned CW = (XH > PW) ? XH : PW;
  localparam int unsigned NM = 6;
  localparam logic signed [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

  // saturate to W bits: {overflow, value}
  function automatic logic [W:0] sat_fn(logic signed [SW-1:0] v);
    logic [SW-W:0] hi;
    hi = v[SW-1:W-1];
    if ((&hi) || (~|hi)) begin
      return {1'b0, v[W-1:0]};
    end else if (v[SW-1]) begin
      return {1'b1, SAT_MIN};
    end
    return {1'b1, SAT_MAX};
  endfunction

  // signed quotient from magnitude: {overflow, value}
  function automatic logic [W:0] quo_fn(logic [W-1:0] q, logic neg, logic big);
    logic [W-1:0] nq;
    nq = -q;
    if (neg) begin
      if (big || (q[W-1] && (|q[W-2:0]))) begin
        return {1'b1, SAT_MIN};
      end
      return {1'b0, nq};
    end
    if (big || q[W-1]) begin
      return {1'b1, SAT_MAX};
    end
    return {1'b0, q};
  endfunction

  logic en;
  logic out_valid_q;

  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  // ---------------- stage 1: partial products of six multiplications ----------
  logic signed [W-1:0]      mx [NM];
  logic signed [W-1:0]      my [NM];
  logic signed [2*HW-1:0]   hh_d [NM];
  logic signed [HW+H:0]     hl_d [NM];
  logic signed [HW+H:0]     lh_d [NM];
  logic [2*H-1:0]           ll_d [NM];

  logic                     s1_valid_q;
  cmd_e                     s1_cmd_q;
  logic signed [W-1:0]      s1_a_q [2];
  logic signed [W-1:0]      s1_b_q [2];
  logic                     s1_zdiv_q, s1_eq_q;
  logic signed [2*HW-1:0]   s1_hh_q [NM];
  logic signed [HW+H:0]     s1_hl_q [NM];
  logic signed [HW+H:0]     s1_lh_q [NM];
  logic [2*H-1:0]           s1_ll_q [NM];

  // ar*br, ai*bi, ar*bi, ai*br, br*br, bi*bi
  always_comb begin
    mx[0] = in_i.a_re;  my[0] = in_i.b_re;
    mx[1] = in_i.a_im;  my[1] = in_i.b_im;
    mx[2] = in_i.a_re;  my[2] = in_i.b_im;
    mx[3] = in_i.a_im;  my[3] = in_i.b_re;
    mx[4] = in_i.b_re;  my[4] = in_i.b_re;
    mx[5] = in_i.b_im;  my[5] = in_i.b_im;
    for (int j = 0; j < NM; j++) begin
      hh_d[j] = $signed(mx[j][W-1:H]) * $signed(my[j][W-1:H]);
      hl_d[j] = $signed(mx[j][W-1:H]) * $signed({1'b0, my[j][H-1:0]});
      lh_d[j] = $signed({1'b0, mx[j][H-1:0]}) * $signed(my[j][W-1:H]);
      ll_d[j] = mx[j][H-1:0] * my[j][H-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_cmd_q  <= cmd_e'(in_i.cmd);
      s1_a_q[0] <= in_i.a_re;
      s1_a_q[1] <= in_i.a_im;
      s1_b_q[0] <= in_i.b_re;
      s1_b_q[1] <= in_i.b_im;
      s1_zdiv_q <= (cmd_e'(in_i.cmd) == CMD_DIV) && (in_i.b_re == '0) && (in_i.b_im == '0);
      s1_eq_q   <= (cmd_e'(in_i.cmd) == CMD_EQ) && (in_i.a_re == in_i.b_re) &&
                   (in_i.a_im == in_i.b_im);
      s1_hh_q   <= hh_d;
      s1_hl_q   <= hl_d;
      s1_lh_q   <= lh_d;
      s1_ll_q   <= ll_d;
    end
  end

  // ---------------- stage 2: assemble full products ---------------------------
  logic signed [PW-1:0] prod_d [NM];
  logic                 s2_valid_q;
  cmd_e                 s2_cmd_q;
  logic signed [W-1:0]  s2_a_q [2];
  logic signed [W-1:0]  s2_b_q [2];
  logic                 s2_zdiv_q, s2_eq_q;
  logic signed [PW-1:0] s2_prod_q [NM];

  always_comb begin
    for (int j = 0; j < NM; j++) begin
      prod_d[j] = (PW'(s1_hh_q[j]) <<< (2 * H)) +
                  ((PW'(s1_hl_q[j]) + PW'(s1_lh_q[j])) <<< H) + PW'(s1_ll_q[j]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_cmd_q  <= s1_cmd_q;
      s2_a_q    <= s1_a_q;
      s2_b_q    <= s1_b_q;
      s2_zdiv_q <= s1_zdiv_q;
      s2_eq_q   <= s1_eq_q;
      s2_prod_q <= prod_d;
    end
  end

  // ---------------- stage 3: sums, product scaling, divide terms --------------
  logic signed [SW-1:0] mul_d [2];
  logic signed [SW-1:0] val_d [2];
  logic signed [NW-1:0] num_d [2];
  logic [PW-1:0]        den_d;

  logic                 s3_valid_q;
  cmd_e                 s3_cmd_q;
  logic                 s3_zdiv_q, s3_eq_q;
  logic signed [SW-1:0] s3_val_q [2];
  logic signed [NW-1:0] s3_num_q [2];
  logic [PW-1:0]        s3_den_q;

  always_comb begin
    mul_d[0] = (SW'(s2_prod_q[0]) - SW'(s2_prod_q[1])) >>> F;
    mul_d[1] = (SW'(s2_prod_q[2]) + SW'(s2_prod_q[3])) >>> F;
    num_d[0] = NW'(s2_prod_q[0]) + NW'(s2_prod_q[1]);   // ar*br + ai*bi
    num_d[1] = NW'(s2_prod_q[3]) - NW'(s2_prod_q[2]);   // ai*br - ar*bi
    den_d    = $unsigned(s2_prod_q[4]) + $unsigned(s2_prod_q[5]);
    for (int l = 0; l < 2; l++) begin
      case (s2_cmd_q)
        CMD_ADD: val_d[l] = SW'(s2_a_q[l]) + SW'(s2_b_q[l]);
        CMD_SUB: val_d[l] = SW'(s2_a_q[l]) - SW'(s2_b_q[l]);
        CMD_MUL: val_d[l] = mul_d[l];
        default: val_d[l] = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_cmd_q  <= s2_cmd_q;
      s3_zdiv_q <= s2_zdiv_q;
      s3_eq_q   <= s2_eq_q;
      s3_val_q  <= val_d;
      s3_num_q  <= num_d;
      s3_den_q  <= den_d;
    end
  end

  // ---------------- stage 4: saturate simple ops, dividend magnitude ----------
  logic [W:0]    sat_d [2];
  logic [PW-1:0] mag_d [2];
  logic          arith;

  logic          s4_valid_q;
  logic          s4_is_div_q, s4_zdiv_q, s4_eq_q, s4_ovf_q;
  logic [W-1:0]  s4_res_q [2];
  logic [PW-1:0] s4_mag_q [2];
  logic [1:0]    s4_neg_q;
  logic [PW-1:0] s4_den_q;

  assign arith = (s3_cmd_q == CMD_ADD) || (s3_cmd_q == CMD_SUB) || (s3_cmd_q == CMD_MUL);

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      sat_d[l] = sat_fn(s3_val_q[l]);
      mag_d[l] = s3_num_q[l][NW-1] ? PW'(-s3_num_q[l]) : PW'(s3_num_q[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (en) begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_is_div_q <= (s3_cmd_q == CMD_DIV);
      s4_zdiv_q   <= s3_zdiv_q;
      s4_eq_q     <= s3_eq_q;
      s4_ovf_q    <= arith && (sat_d[0][W] || sat_d[1][W]);
      s4_res_q[0] <= sat_d[0][W-1:0];
      s4_res_q[1] <= sat_d[1][W-1:0];
      s4_mag_q    <= mag_d;
      s4_neg_q    <= {s3_num_q[1][NW-1], s3_num_q[0][NW-1]};
      s4_den_q    <= s3_den_q;
    end
  end

  // ---------------- stage 5: range check and first partial remainder ----------
  logic [NX-1:0] xs_d  [2];
  logic [CW-1:0] xh_d  [2];
  logic [1:0]    big_d;

  logic          s5_valid_q;
  div_ctl_t      s5_ctl_q;
  logic [PW-1:0] s5_den_q;
  logic [PW-1:0] s5_rem_q [2];
  logic [W-1:0]  s5_xlo_q [2];
  logic [W-1:0]  s5_res_q [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      xs_d[l]  = NX'(s4_mag_q[l]) << F;
      xh_d[l]  = CW'(xs_d[l][NX-1:W]);
      big_d[l] = xh_d[l] >= CW'(s4_den_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_valid_q <= 1'b0;
    end else if (en) begin
      s5_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_ctl_q.is_div <= s4_is_div_q;
      s5_ctl_q.zdiv   <= s4_zdiv_q;
      s5_ctl_q.eq     <= s4_eq_q;
      s5_ctl_q.ovf    <= s4_ovf_q;
      s5_ctl_q.neg    <= s4_neg_q;
      s5_ctl_q.big    <= big_d;
      s5_den_q        <= s4_den_q;
      for (int l = 0; l < 2; l++) begin
        s5_rem_q[l] <= xh_d[l][PW-1:0];
        s5_xlo_q[l] <= xs_d[l][W-1:0];
      end
      s5_res_q <= s4_res_q;
    end
  end

  // ---------------- quotient bits, one per stage ------------------------------
  logic          dv_valid;
  div_ctl_t      dv_ctl;
  logic [W-1:0]  dv_q   [2];
  logic [W-1:0]  dv_res [2];

  cau_div #(
    .DW (W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s5_valid_q),
    .ctl_i   (s5_ctl_q),
    .den_i   (s5_den_q),
    .rem_i   (s5_rem_q),
    .xlo_i   (s5_xlo_q),
    .res_i   (s5_res_q),
    .valid_o (dv_valid),
    .ctl_o   (dv_ctl),
    .q_o     (dv_q),
    .res_o   (dv_res)
  );

  // ---------------- output register -------------------------------------------
  logic [W:0]          quo_d [2];
  logic signed [W-1:0] out_re_d, out_im_d;
  logic                out_ovf_d;
  logic signed [W-1:0] out_re_q, out_im_q;
  logic                out_eq_q, out_zdiv_q, out_ovf_q;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      quo_d[l] = quo_fn(dv_q[l], dv_ctl.neg[l], dv_ctl.big[l]);
    end
    if (!dv_ctl.is_div) begin
      out_re_d  = dv_res[0];
      out_im_d  = dv_res[1];
      out_ovf_d = dv_ctl.ovf;
    end else if (dv_ctl.zdiv) begin
      out_re_d  = '0;
      out_im_d  = '0;
      out_ovf_d = 1'b0;
    end else begin
      out_re_d  = quo_d[0][W-1:0];
      out_im_d  = quo_d[1][W-1:0];
      out_ovf_d = quo_d[0][W] || quo_d[1][W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_re_q   <= out_re_d;
      out_im_q   <= out_im_d;
      out_eq_q   <= dv_ctl.eq;
      out_zdiv_q <= dv_ctl.zdiv;
      out_ovf_q  <= out_ovf_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.res_re       = out_re_q;
  assign out_o.res_im       = out_im_q;
  assign out_o.equal_flag   = out_eq_q;
  assign out_o.zero_divisor = out_zdiv_q;
  assign out_o.overflow     = out_ovf_q;

  // ---------------- checks ----------------------------------------------------
`include "complex_arithmetic_unit_assert.svh"

  `CAU_ASSERT(a_zdiv_clean, out_valid_q && out_zdiv_q |-> out_re_q == '0 && out_im_q == '0 && !out_ovf_q, "zero divisor result not cleared")
  `CAU_NEVER(a_eq_excl, out_valid_q && out_eq_q && (out_ovf_q || out_zdiv_q), "compare result carries arithmetic flags")
  `CAU_ASSERT(a_ovf_sat, out_valid_q && out_ovf_q |-> out_re_q == SAT_MAX || out_re_q == SAT_MIN || out_im_q == SAT_MAX || out_im_q == SAT_MIN, "overflow without saturated part")
  `CAU_ASSERT(a_hold, out_valid_q && !out_o.ready |=> out_valid_q && $stable(dv_valid) && $stable(s1_valid_q), "pipeline moved during a stall")

endmodule
